/* src/irtx_pkg.sv */
// irtx_pkg: shared types and constants of the nec ir frame transmitter
// phase codes, register indexes, timing register bundle and item structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package irtx_pkg;

    localparam int FRAME_BITS = 32;
    localparam int TICK_W     = 12;
    localparam int BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int CFG_IDX_W  = 3;

    // frame phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HDR_MARK = 3'd1;
    localparam logic [2:0] PH_HDR_SPC  = 3'd2;
    localparam logic [2:0] PH_BIT_MARK = 3'd3;
    localparam logic [2:0] PH_BIT_SPC  = 3'd4;
    localparam logic [2:0] PH_END_MARK = 3'd5;
    localparam logic [2:0] PH_GAP      = 3'd6;

    // timing register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 3'd4;

    localparam logic [TICK_W-1:0] RST_SHORT      = 12'd21;
    localparam logic [TICK_W-1:0] RST_LONG       = 12'd63;
    localparam logic [TICK_W-1:0] RST_HDR_MARK   = 12'd339;
    localparam logic [TICK_W-1:0] RST_HDR_SPACE  = 12'd170;
    localparam logic [TICK_W-1:0] RST_IDLE       = 12'd1492;

    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] header_mark_ticks;
        logic [TICK_W-1:0] header_space_ticks;
        logic [TICK_W-1:0] idle_ticks;
    } timing_t;

    typedef struct packed {
        logic       func;
        logic [7:0] address;
        logic [7:0] command;
        logic       complete;
    } item_t;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } result_t;

endpackage

`default_nettype wire

/* src/irtx_cfg_regs.sv */
// irtx_cfg_regs: timing registers written through the configuration channel
// depends on irtx_pkg
`timescale 1ns / 1ps
`default_nettype none

module irtx_cfg_regs
    import irtx_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    output timing_t                   timing
);

    timing_t timing_reg;
    timing_t timing_next;

    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    always_comb begin
        timing_next = timing_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SHORT:     timing_next.short_ticks        = cfg_data;
                REG_LONG:      timing_next.long_ticks         = cfg_data;
                REG_HDR_MARK:  timing_next.header_mark_ticks  = cfg_data;
                REG_HDR_SPACE: timing_next.header_space_ticks = cfg_data;
                REG_IDLE:      timing_next.idle_ticks         = cfg_data;
                default:       timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.short_ticks        <= RST_SHORT;
            timing_reg.long_ticks         <= RST_LONG;
            timing_reg.header_mark_ticks  <= RST_HDR_MARK;
            timing_reg.header_space_ticks <= RST_HDR_SPACE;
            timing_reg.idle_ticks         <= RST_IDLE;
        end else begin
            timing_reg <= timing_next;
        end
    end

endmodule

`default_nettype wire

/* src/irtx_in_reg.sv */
// irtx_in_reg: input register stage holding one accepted item
// depends on irtx_pkg
`timescale 1ns / 1ps
`default_nettype none

module irtx_in_reg
    import irtx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       held_valid,
    output item_t      held_item,
    input  wire logic  take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // refill in the same cycle the held item is consumed
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

/* src/irtx_fsm.sv */
// irtx_fsm: frame phase sequencer, tick counter and data shift register
// computes one result per consumed item; depends on irtx_pkg
`timescale 1ns / 1ps
`default_nettype none

module irtx_fsm
    import irtx_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    fire,
    input  wire item_t   item,
    input  wire timing_t timing,
    output result_t      result
);

    logic [2:0]            phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;

    logic [2:0]        phase_cur;
    logic [TICK_W-1:0] len;
    logic [TICK_W:0]   tick_inc;
    logic              phase_end;

    assign phase_cur = (phase_reg > PH_GAP) ? PH_IDLE : phase_reg;
    assign tick_inc  = {1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1};
    // a zero length still ends after one tick
    assign phase_end = tick_inc >= {1'b0, len};

    always_comb begin
        unique case (phase_cur)
            PH_HDR_MARK: len = timing.header_mark_ticks;
            PH_HDR_SPC:  len = timing.header_space_ticks;
            PH_BIT_MARK: len = timing.short_ticks;
            PH_BIT_SPC:  len = shift_reg[0] ? timing.long_ticks : timing.short_ticks;
            PH_END_MARK: len = timing.short_ticks;
            PH_GAP:      len = timing.idle_ticks;
            default:     len = {{(TICK_W-1){1'b0}}, 1'b1};
        endcase
    end

    always_comb begin
        phase_next = phase_cur;
        tick_next  = tick_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        result     = '0;
        if (item.func) begin
            result.busy_res = 1'b1;
            if (phase_cur == PH_IDLE) begin
                shift_next = {~item.command, item.command, ~item.address, item.address};
                bits_next  = BITS_W'(FRAME_BITS);
                tick_next  = '0;
                phase_next = PH_HDR_MARK;
            end else begin
                result.rejected = 1'b1;
            end
        end else if (phase_cur != PH_IDLE) begin
            result.busy_res   = 1'b1;
            result.carrier_on = (phase_cur == PH_HDR_MARK) || (phase_cur == PH_BIT_MARK) ||
                                (phase_cur == PH_END_MARK);
            if (phase_end) begin
                tick_next = '0;
                unique case (phase_cur)
                    PH_HDR_MARK: phase_next = PH_HDR_SPC;
                    PH_HDR_SPC:  phase_next = PH_BIT_MARK;
                    PH_BIT_MARK: phase_next = PH_BIT_SPC;
                    PH_BIT_SPC: begin
                        shift_next = shift_reg >> 1;
                        if (bits_reg <= BITS_W'(1)) begin
                            bits_next  = '0;
                            phase_next = item.complete ? PH_END_MARK : PH_GAP;
                        end else begin
                            bits_next  = bits_reg - BITS_W'(1);
                            phase_next = PH_BIT_MARK;
                        end
                    end
                    PH_END_MARK: phase_next = PH_GAP;
                    default: begin
                        result.frame_done = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                endcase
            end else begin
                tick_next = tick_inc[TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bits_reg  <= '0;
            shift_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
        end
    end

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= BITS_W'(FRAME_BITS))
        else $error("bit counter above frame length");

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.func && !result.rejected |=> phase_reg == PH_HDR_MARK && tick_reg == '0)
        else $error("accepted load did not start the header mark");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.frame_done |=> phase_reg == PH_IDLE)
        else $error("frame end did not return to idle");

    a_idle_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_cur == PH_BIT_SPC && phase_next == PH_GAP |-> bits_next == '0)
        else $error("gap entered with data bits left");

endmodule

`default_nettype wire

/* src/irtx_out_reg.sv */
// irtx_out_reg: result register toward the master side
// depends on irtx_pkg
`timescale 1ns / 1ps
`default_nettype none

module irtx_out_reg
    import irtx_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    output logic         can_load,
    input  wire result_t result,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

/* src/nec_ir_frame_transmitter_core.sv */
// nec_ir_frame_transmitter_core: carrier gate generator for nec ir frames
// depends on irtx_pkg, irtx_cfg_regs, irtx_in_reg, irtx_fsm, irtx_out_reg
//
// usage
//   s_ channel: one transaction per carrier period tick (s_tuser = 0) or a
//   frame load (s_tuser = 1) carrying address, command and the complete flag.
//   m_ channel: one result transaction per input transaction, in order;
//   m_tlast marks the tick that ends the closing idle gap.
//   cfg channel: writes timing register cfg_index with cfg_data; always ready. the user
//   must write it only while no transaction is in flight; the block does not enforce this.
// path and throughput
//   an accepted input transaction waits in the input register; the phase sequencer
//   computes its result as it is loaded into the result register; one transaction per
//   cycle is sustained while the receiver keeps up, set by the combinational phase
//   sequencer between the input register and the result register.
// stalls and reset
//   with m_tready low the result register holds, the input register fills,
//   and s_tready drops until the receiver takes the pending result.
//   reset clears both stages, returns the sequencer to idle and loads the
//   default timing values.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_transmitter_core
    import irtx_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,  // address[7:0], command[15:8], complete[16]
    input  wire logic                 s_tuser,  // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,  // carrier_on[0], busy_res[1], rejected[2]
    output logic                      m_tlast,  // frame_done
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data
);

    timing_t timing;
    item_t   s_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_can_load;
    logic    fire;
    result_t result;
    result_t m_result;

    assign s_item.func     = s_tuser;
    assign s_item.address  = s_tdata[7:0];
    assign s_item.command  = s_tdata[15:8];
    assign s_item.complete = s_tdata[16];

    assign fire = held_valid && out_can_load;

    irtx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    irtx_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (fire)
    );

    irtx_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (held_item),
        .timing  (timing),
        .result  (result)
    );

    irtx_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .can_load   (out_can_load),
        .result     (result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_result)
    );

    assign m_tdata = {5'b0, m_result.rejected, m_result.busy_res, m_result.carrier_on};
    assign m_tlast = m_result.frame_done;

endmodule

`default_nettype wire

/* test/nec_ir_frame_transmitter_core_tb.sv */
// nec_ir_frame_transmitter_core_tb: self-checking bench for the nec ir carrier gate
// drives tick and load transactions under random sender gaps and receiver stalls and
// compares every result to an in-bench sequencer or a directed row; depends on irtx_pkg
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_core_tb;
    import irtx_pkg::*;

    localparam int          RESET_CYCLES     = 9;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          N_SETTINGS       = 6;
    localparam int          RAND_PER_SETTING = 165;
    localparam int          TAIL_TICKS       = 40;
    localparam logic [11:0] TICK_MAX         = 12'd4095;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // short timing used to close a frame that was started with long phases
    localparam timing_t QUICK_TIMING = '{12'd1, 12'd2, 12'd1, 12'd1, 12'd1};

    // result_t order: carrier_on, busy_res, frame_done, rejected
    localparam result_t OUT_QUIET  = '{1'b0, 1'b0, 1'b0, 1'b0};
    localparam result_t OUT_BUSY   = '{1'b0, 1'b1, 1'b0, 1'b0};
    localparam result_t OUT_REJECT = '{1'b0, 1'b1, 1'b0, 1'b1};
    localparam result_t OUT_MARK   = '{1'b1, 1'b1, 1'b0, 1'b0};

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } row_t;

    // runs at reset timing, the frame started here is then shortened and ticked out
    localparam int   ROWS = 6;
    localparam row_t DIRECTED [ROWS] = '{
        '{'{FUNC_TICK, 8'hFF, 8'hFF, 1'b1}, 1'b1, OUT_QUIET},   // tick while idle
        '{'{FUNC_LOAD, 8'h00, 8'h00, 1'b0}, 1'b1, OUT_BUSY},    // load while idle
        '{'{FUNC_LOAD, 8'hFF, 8'hFF, 1'b1}, 1'b1, OUT_REJECT},  // load while busy
        '{'{FUNC_TICK, 8'h00, 8'h00, 1'b0}, 1'b1, OUT_MARK},    // header mark
        '{'{FUNC_TICK, 8'hAA, 8'h55, 1'b1}, 1'b1, OUT_MARK},    // complete ignored mid-frame
        '{'{FUNC_LOAD, 8'h5A, 8'hA5, 1'b0}, 1'b1, OUT_REJECT}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;    // address[7:0], command[15:8], complete[16]
    logic                 s_tuser   = 1'b0;  // func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;           // carrier_on[0], busy_res[1], rejected[2]
    logic                 m_tlast;           // frame_done
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_data  = '0;

    // sequencer copy used for prediction
    timing_t          gate_timing;
    logic [2:0]       gate_phase;
    logic [TICK_W-1:0] ticks_in_phase;
    logic [BITS_W-1:0] bits_pending;
    logic [31:0]      code_shift;

    result_t     expected_gates[$];
    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned items_sent     = 0;
    int unsigned frames_closed  = 0;
    int unsigned loads_refused  = 0;
    int unsigned settings_run   = 0;
    int unsigned burst_left     = 0;
    int unsigned cycle_count    = 0;
    int unsigned ready_left     = 0;
    int unsigned ready_mode     = 0;

    nec_ir_frame_transmitter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [TICK_W-1:0] phase_ticks();
        case (gate_phase)
            PH_HDR_MARK: phase_ticks = gate_timing.header_mark_ticks;
            PH_HDR_SPC:  phase_ticks = gate_timing.header_space_ticks;
            PH_BIT_MARK: phase_ticks = gate_timing.short_ticks;
            PH_BIT_SPC:  phase_ticks = code_shift[0] ? gate_timing.long_ticks
                                                     : gate_timing.short_ticks;
            PH_END_MARK: phase_ticks = gate_timing.short_ticks;
            PH_GAP:      phase_ticks = gate_timing.idle_ticks;
            default:     phase_ticks = 12'd1;
        endcase
    endfunction

    // advances the sequencer copy by one transaction and returns the gate it produces
    function automatic result_t next_gate(input item_t it);
        result_t           r;
        logic [TICK_W-1:0] span;
        r = OUT_QUIET;
        if (gate_phase > PH_GAP) gate_phase = PH_IDLE;
        if (it.func == FUNC_LOAD) begin
            if (gate_phase == PH_IDLE) begin
                code_shift     = {~it.command, it.command, ~it.address, it.address};
                bits_pending   = BITS_W'(FRAME_BITS);
                ticks_in_phase = '0;
                gate_phase     = PH_HDR_MARK;
            end else begin
                r.rejected = 1'b1;
            end
            r.busy_res = 1'b1;
        end else if (gate_phase != PH_IDLE) begin
            span         = phase_ticks();
            r.busy_res   = 1'b1;
            r.carrier_on = (gate_phase == PH_HDR_MARK) || (gate_phase == PH_BIT_MARK) ||
                           (gate_phase == PH_END_MARK);
            // a zero length ends the phase after one tick, like a length of one
            if ({1'b0, ticks_in_phase} + 13'd1 >= {1'b0, span}) begin
                ticks_in_phase = '0;
                case (gate_phase)
                    PH_HDR_MARK: gate_phase = PH_HDR_SPC;
                    PH_HDR_SPC:  gate_phase = PH_BIT_MARK;
                    PH_BIT_MARK: gate_phase = PH_BIT_SPC;
                    PH_BIT_SPC: begin
                        code_shift = code_shift >> 1;
                        if (bits_pending <= 1) begin
                            bits_pending = '0;
                            gate_phase   = it.complete ? PH_END_MARK : PH_GAP;
                        end else begin
                            bits_pending = bits_pending - 1'b1;
                            gate_phase   = PH_BIT_MARK;
                        end
                    end
                    PH_END_MARK: gate_phase = PH_GAP;
                    default: begin
                        r.frame_done = 1'b1;
                        gate_phase   = PH_IDLE;
                    end
                endcase
            end else begin
                ticks_in_phase = ticks_in_phase + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic item_t pick_gate();
        item_t it;
        it.address  = 8'($urandom);
        it.command  = 8'($urandom);
        it.complete = 1'($urandom_range(0, 1));
        if (gate_phase == PH_IDLE)
            it.func = ($urandom_range(0, 9) < 6) ? FUNC_LOAD : FUNC_TICK;
        else
            it.func = ($urandom_range(0, 31) == 0) ? FUNC_LOAD : FUNC_TICK;
        return it;
    endfunction

    task automatic send_gate(input item_t it, input bit typed, input result_t want);
        result_t     got;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.complete, it.command, it.address};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = next_gate(it);
        if (got.frame_done) frames_closed++;
        if (got.rejected) loads_refused++;
        expected_gates.push_back(typed ? want : got);
        items_sent++;
    endtask

    // ticks until the sequencer copy is back to idle
    task automatic finish_frame(input bit end_mark);
        item_t it;
        while (gate_phase != PH_IDLE) begin
            it.func     = FUNC_TICK;
            it.address  = 8'($urandom);
            it.command  = 8'($urandom);
            it.complete = end_mark ? 1'b1 : 1'($urandom_range(0, 1));
            send_gate(it, 1'b0, OUT_QUIET);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_gates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SHORT:     gate_timing.short_ticks        = val;
            REG_LONG:      gate_timing.long_ticks         = val;
            REG_HDR_MARK:  gate_timing.header_mark_ticks  = val;
            REG_HDR_SPACE: gate_timing.header_space_ticks = val;
            REG_IDLE:      gate_timing.idle_ticks         = val;
            default: ;
        endcase
    endtask

    task automatic load_timing(input timing_t plan, input bit stray_writes);
        write_reg(REG_SHORT, plan.short_ticks);
        write_reg(REG_LONG, plan.long_ticks);
        write_reg(REG_HDR_MARK, plan.header_mark_ticks);
        write_reg(REG_HDR_SPACE, plan.header_space_ticks);
        write_reg(REG_IDLE, plan.idle_ticks);
        // indexes past the last register must leave the timing alone
        if (stray_writes)
            for (int k = REG_IDLE + 1; k < (1 << CFG_IDX_W); k++)
                write_reg(CFG_IDX_W'(k), TICK_W'($urandom));
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // receiver: stretches of full rate, partial rate and hard stalls
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(4, 40);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_gates.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                want = expected_gates.pop_front();
                if (m_tdata[0] !== want.carrier_on) begin
                    $error("carrier_on: expected %0b, got %0b", want.carrier_on, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, m_tdata[1]);
                    mismatches++;
                end
                if (m_tlast !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done, m_tlast);
                    mismatches++;
                end
                if (m_tdata[2] !== want.rejected) begin
                    $error("rejected: expected %0b, got %0b", want.rejected, m_tdata[2]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_gates.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        timing_t     plan;
        item_t       it;
        int unsigned counted;
        bit          refused;
        gate_timing    = '{RST_SHORT, RST_LONG, RST_HDR_MARK, RST_HDR_SPACE, RST_IDLE};
        gate_phase     = PH_IDLE;
        ticks_in_phase = '0;
        bits_pending   = '0;
        code_shift     = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < ROWS; r++)
            send_gate(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].want);
        // frame started at reset timing, shortened mid-frame, closing with the trailing mark
        settle();
        load_timing(QUICK_TIMING, 1'b0);
        finish_frame(1'b1);
        settle();

        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p == 0) begin
                plan = '0;
            end else if (p == 1) begin
                plan = '{12'd1, 12'd1, 12'd1, 12'd1, 12'd1};
            end else if (p == N_SETTINGS - 2) begin
                plan = '{12'd1, 12'd2, TICK_MAX, TICK_MAX, TICK_MAX};
            end else if (p == N_SETTINGS - 1) begin
                plan = '{TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX};
            end else begin
                plan.short_ticks        = TICK_W'($urandom_range(0, 3));
                plan.long_ticks         = TICK_W'($urandom_range(0, 6));
                plan.header_mark_ticks  = TICK_W'($urandom_range(0, 8));
                plan.header_space_ticks = TICK_W'($urandom_range(0, 8));
                plan.idle_ticks         = TICK_W'($urandom_range(0, 10));
            end
            load_timing(plan, (p == 0) || ($urandom_range(0, 1) == 1));

            if (p < N_SETTINGS - 2) begin
                counted = 0;
                while (counted < RAND_PER_SETTING) begin
                    it      = pick_gate();
                    refused = (it.func == FUNC_LOAD) && (gate_phase != PH_IDLE);
                    send_gate(it, 1'b0, OUT_QUIET);
                    if (!refused) counted++;
                end
                finish_frame(1'b0);
                settle();
            end else begin
                it      = pick_gate();
                it.func = FUNC_LOAD;
                send_gate(it, 1'b0, OUT_QUIET);
                // long timing: a stretch of the header mark, then shortened mid-frame
                for (int t = 0; t < TAIL_TICKS; t++) begin
                    it      = pick_gate();
                    it.func = FUNC_TICK;
                    send_gate(it, 1'b0, OUT_QUIET);
                end
                settle();
                load_timing(QUICK_TIMING, 1'b0);
                finish_frame(p == N_SETTINGS - 1);
                settle();
            end
        end

        if (expected_gates.size() != 0) begin
            $error("%0d expected results never arrived", expected_gates.size());
            mismatches++;
        end
        $display("sent %0d transactions over %0d timing settings, %0d results checked",
                 items_sent, settings_run, results_seen);
        $display("frames closed: %0d, loads refused while busy: %0d",
                 frames_closed, loads_refused);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
src/irtx_pkg.sv
src/irtx_cfg_regs.sv
src/irtx_in_reg.sv
src/irtx_fsm.sv
src/irtx_out_reg.sv
src/nec_ir_frame_transmitter_core.sv
test/nec_ir_frame_transmitter_core_tb.sv
